### sv/consensus_append_fast_ack_macros.svh
// Assertion macros for the consensus append fast-ack block.
// Used by the checker; needs clk_i and rst_ni in the scope of each use.
`ifndef CONSENSUS_APPEND_FAST_ACK_MACROS_SVH
`define CONSENSUS_APPEND_FAST_ACK_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CAFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When pre holds, post must hold at the next clock edge.
`define CAFA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/cafa_pkg.sv
// Shared types and constants of the consensus append fast-ack block.
// No dependencies; imported by the top level, cafa_decide, checker and testbench.
package cafa_pkg;

  localparam logic [15:0] DEFAULT_PORT = 16'd9000;
  localparam logic [7:0]  APPEND_TYPE  = 8'h20;
  localparam logic [15:0] MIN_PAYLOAD  = 16'd35;
  // The ring depth must be a power of two; the slot is the low index bits.
  localparam int          RING_DEPTH_DEF = 4096;

  localparam logic [3:0] OUT_NOT_OURS  = 4'd0;
  localparam logic [3:0] OUT_OTHER     = 4'd1;
  localparam logic [3:0] OUT_WRONG_LDR = 4'd2;
  localparam logic [3:0] OUT_TRUNC     = 4'd3;
  localparam logic [3:0] OUT_STALE     = 4'd4;
  localparam logic [3:0] OUT_MISMATCH  = 4'd5;
  localparam logic [3:0] OUT_GAP       = 4'd6;
  localparam logic [3:0] OUT_APPENDED  = 4'd7;
  localparam logic [3:0] OUT_HEARTBEAT = 4'd8;
  localparam logic [3:0] OUT_DUPLICATE = 4'd9;

  typedef struct packed {
    logic        header_ok;
    logic [15:0] dest_port;
    logic [31:0] src_addr;
    logic [15:0] avail_len;
    logic [7:0]  msg_type;
    logic [31:0] msg_term;
    logic [31:0] entry_index;
    logic [31:0] prior_index;
    logic [31:0] prior_term;
    logic [15:0] sender_node;
    logic [15:0] entry_len;
    logic [63:0] now_time;
  } in_t;

  typedef struct packed {
    logic        verdict;
    logic [3:0]  outcome;
    logic [31:0] reply_index;
    logic        appended;
    logic [31:0] ev_term;
    logic [31:0] ev_prior_index;
    logic [31:0] ev_prior_term;
    logic [15:0] ev_len;
    logic [15:0] ev_node;
    logic [63:0] ev_time;
    logic [63:0] seen_time;
    logic [31:0] term_now;
  } out_t;

  // Follower state kept in flip-flops.
  typedef struct packed {
    logic [31:0] leader_term;
    logic [31:0] tail_idx;
    logic [31:0] tail_term;
    logic [31:0] leader_addr;
    logic [63:0] heard_at;
  } st_t;

  // One ring entry: tag in the upper half, term in the lower half.
  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] term;
  } ring_t;

endpackage

### sv/consensus_append_fast_ack.sv
// Follower fast path for log-replication requests: sequencer, state and ring.
// Depends on cafa_pkg, cafa_ram and cafa_decide.
//
// Use: present one parsed request header on item_i with start high; it is
// taken at a clock edge where busy is low. Write listen_port through
// cfg_we_i/cfg_wdata_i while the block is idle; reset value is 9000.
// Each request gives exactly one result beat on res_o, marked by res_valid_o
// for one cycle and registered at the end of the ST_LOOK state that follows the
// request being taken. The receiver cannot stall, so the result is simply
// presented and dropped. At the accepting edge the RAM registers the ring entry
// of the prior index from the term ring; in ST_LOOK the block checks the request,
// updates the state and writes the ring entry of an appended index. busy is high
// in ST_LOOK, so a new request is taken only after the previous one is checked;
// it can be taken while the previous result beat is on the outputs.
// Reset: the state registers clear at once, then a clearing pass writes zero
// to every ring entry, one per cycle. busy is high during that pass;
// configuration writes are taken throughout.
// RING_DEPTH must be a power of two.
module consensus_append_fast_ack #(
  parameter int RING_DEPTH = cafa_pkg::RING_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cafa_pkg::in_t  item_i,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  output logic           res_valid_o,
  output cafa_pkg::out_t res_o
);
  import cafa_pkg::*;

  localparam int IW = $clog2(RING_DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e      state_q;
  logic [IW-1:0] clr_q;
  logic [15:0] listen_port_q;
  st_t         st_q;
  st_t         st_d;
  in_t         item_q;
  out_t        res_q;
  out_t        res_d;
  logic        res_valid_q;
  logic        ring_we_dec;
  logic        accept;
  ring_t       ring_rd;
  ring_t       ring_wd;
  logic        ram_we;
  logic [IW-1:0] ram_waddr;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ring_wd   = '0;
    end else begin
      ram_we       = (state_q == ST_LOOK) && ring_we_dec;
      ram_waddr    = item_q.entry_index[IW-1:0];
      ring_wd.tag  = item_q.entry_index;
      ring_wd.term = item_q.msg_term;
    end
  end

  cafa_ram #(
    .WIDTH($bits(ring_t)),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ring_wd),
    .raddr_i(item_i.prior_index[IW-1:0]),
    .rdata_o(ring_rd)
  );

  cafa_decide u_decide (
    .listen_port_i(listen_port_q),
    .item_i       (item_q),
    .st_i         (st_q),
    .ring_i       (ring_rd),
    .st_o         (st_d),
    .ring_we_o    (ring_we_dec),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_port_q <= DEFAULT_PORT;
    end else if (cfg_we_i) begin
      listen_port_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      st_q        <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IW'(RING_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          st_q        <= st_d;
          res_q       <= res_d;
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### sv/cafa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cafa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/cafa_decide.sv
// Decision logic: checks one request against the follower state and ring entry.
// Depends on cafa_pkg.
module cafa_decide (
  input  logic [15:0]    listen_port_i,
  input  cafa_pkg::in_t  item_i,
  input  cafa_pkg::st_t  st_i,
  input  cafa_pkg::ring_t ring_i,
  output cafa_pkg::st_t  st_o,
  output logic           ring_we_o,
  output cafa_pkg::out_t res_o
);
  import cafa_pkg::*;

  logic        not_ours;
  logic        wrong_ldr;
  logic        trunc;
  logic        prior_ok;
  logic [31:0] next_index;
  logic [16:0] need_len;

  assign not_ours = !item_i.header_ok || (item_i.dest_port != listen_port_i) ||
                    (item_i.avail_len < MIN_PAYLOAD);
  assign wrong_ldr = (st_i.leader_addr != '0) && (st_i.leader_addr != item_i.src_addr);
  assign need_len = {1'b0, MIN_PAYLOAD} + {1'b0, item_i.entry_len};
  assign trunc = need_len > {1'b0, item_i.avail_len};
  assign next_index = st_i.tail_idx + 32'd1;

  always_comb begin
    if (item_i.prior_index == '0 && item_i.prior_term == '0) begin
      prior_ok = 1'b1;
    end else if (item_i.prior_index > st_i.tail_idx) begin
      prior_ok = 1'b0;
    end else if (item_i.prior_index == st_i.tail_idx) begin
      prior_ok = item_i.prior_term == st_i.tail_term;
    end else begin
      prior_ok = (ring_i.tag == item_i.prior_index) && (ring_i.term == item_i.prior_term);
    end
  end

  always_comb begin
    st_o      = st_i;
    ring_we_o = 1'b0;
    res_o     = '0;
    if (not_ours) begin
      res_o.outcome = OUT_NOT_OURS;
    end else if (item_i.msg_type != APPEND_TYPE) begin
      res_o.outcome = OUT_OTHER;
    end else if (wrong_ldr) begin
      res_o.outcome = OUT_WRONG_LDR;
    end else begin
      // The first source seen is latched even if a later check fails.
      if (st_i.leader_addr == '0) begin
        st_o.leader_addr = item_i.src_addr;
      end
      if (trunc) begin
        res_o.outcome = OUT_TRUNC;
      end else if (item_i.msg_term < st_i.leader_term) begin
        res_o.outcome = OUT_STALE;
      end else begin
        st_o.leader_term = item_i.msg_term;
        if (!prior_ok) begin
          res_o.outcome = OUT_MISMATCH;
        end else begin
          st_o.heard_at = item_i.now_time;
          if (item_i.entry_index == '0 && item_i.entry_len == '0) begin
            res_o.outcome = OUT_HEARTBEAT;
            res_o.verdict = 1'b1;
          end else if (item_i.entry_index == next_index && item_i.entry_len != '0) begin
            ring_we_o            = 1'b1;
            st_o.tail_idx        = item_i.entry_index;
            st_o.tail_term       = item_i.msg_term;
            res_o.outcome        = OUT_APPENDED;
            res_o.verdict        = 1'b1;
            res_o.appended       = 1'b1;
            res_o.ev_term        = item_i.msg_term;
            res_o.ev_prior_index = item_i.prior_index;
            res_o.ev_prior_term  = item_i.prior_term;
            res_o.ev_len         = item_i.entry_len;
            res_o.ev_node        = item_i.sender_node;
            res_o.ev_time        = item_i.now_time;
          end else if (item_i.entry_index <= st_i.tail_idx) begin
            res_o.outcome = OUT_DUPLICATE;
            res_o.verdict = 1'b1;
          end else begin
            res_o.outcome = OUT_GAP;
          end
          if (res_o.verdict) begin
            res_o.reply_index = (item_i.entry_index == '0) ? st_o.tail_idx
                                                           : item_i.entry_index;
          end
        end
      end
    end
    res_o.seen_time = st_o.heard_at;
    res_o.term_now  = st_o.leader_term;
  end

endmodule

### sv/cafa_checker.sv
// Port-level assertions for consensus_append_fast_ack, bound to the top level.
// Depends on cafa_pkg and consensus_append_fast_ack_macros.svh.
`include "consensus_append_fast_ack_macros.svh"

module cafa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_valid_o,
  input cafa_pkg::out_t res_o
);
  import cafa_pkg::*;

  logic reply_ok;
  logic append_ok;

  assign reply_ok = !(res_valid_o && res_o.verdict) ||
                    (res_o.outcome inside {OUT_APPENDED, OUT_HEARTBEAT, OUT_DUPLICATE});
  assign append_ok = !res_valid_o || (res_o.appended == (res_o.outcome == OUT_APPENDED));

  // A taken request keeps the block busy for one cycle; its beat comes in the cycle after.
  `CAFA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy && !res_valid_o, "busy dropped")
  `CAFA_ASSERT_NEXT(a_beat_follows, $past(start && !busy), res_valid_o, "result beat missing")
  `CAFA_ASSERT_NEXT(a_single_beat, res_valid_o, !res_valid_o, "result beat repeated")
  `CAFA_ASSERT(a_verdict_code, reply_ok, "reply verdict on a passed outcome")
  `CAFA_ASSERT(a_appended_code, append_ok, "appended flag disagrees with outcome")

endmodule

bind consensus_append_fast_ack cafa_checker u_cafa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

### dv/consensus_append_fast_ack_tb.sv
// Self-checking testbench for the consensus append fast-ack block.
// Drives request beats, predicts each result beat with a local follower model and
// checks it field by field; needs cafa_pkg and the consensus_append_fast_ack RTL.
module consensus_append_fast_ack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cafa_pkg::*;

  localparam int          RING_SLOTS = RING_DEPTH_DEF;
  localparam int          RAND_ITEMS = 1280;
  localparam int          FILL_TO    = 600;
  localparam logic [31:0] LEADER_A   = 32'h0A00_0001;
  localparam logic [31:0] OTHER_SRC  = 32'hFFFF_FFFF;
  localparam logic [63:0] TIME_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic start       = 1'b0;
  in_t  item_i      = '0;
  logic cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic busy;
  logic res_valid_o;
  out_t res_o;

  // Follower model: register, state and term ring.
  logic [15:0] port_q;
  logic [31:0] cur_term;
  logic [31:0] log_last_idx;
  logic [31:0] log_last_term;
  logic [31:0] leader_q;
  logic [63:0] seen_q;
  logic [31:0] tag_mem  [RING_SLOTS];
  logic [31:0] term_mem [RING_SLOTS];

  logic [63:0] clock_ns = 64'd5000;
  out_t        acks_due [$];
  dir_row_t    dir_rows [$];
  int unsigned fails = 0;
  int unsigned gap_count = 0;
  bit          bursty = 1'b1;

  consensus_append_fast_ack DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("consensus_append_fast_ack regression: fail");
    $finish;
  end

  function automatic in_t mk(input logic hdr, input logic [15:0] dport,
                             input logic [31:0] src, input logic [15:0] avail,
                             input logic [7:0] mtype, input logic [31:0] term,
                             input logic [31:0] eidx, input logic [31:0] pidx,
                             input logic [31:0] pterm, input logic [15:0] node,
                             input logic [15:0] elen, input logic [63:0] now);
    in_t r;
    r.header_ok   = hdr;
    r.dest_port   = dport;
    r.src_addr    = src;
    r.avail_len   = avail;
    r.msg_type    = mtype;
    r.msg_term    = term;
    r.entry_index = eidx;
    r.prior_index = pidx;
    r.prior_term  = pterm;
    r.sender_node = node;
    r.entry_len   = elen;
    r.now_time    = now;
    return r;
  endfunction

  // Result with no event attached.
  function automatic out_t brief(input logic v, input logic [3:0] oc, input logic [31:0] reply,
                                 input logic [63:0] seen, input logic [31:0] term);
    out_t r;
    r = '0;
    r.verdict     = v;
    r.outcome     = oc;
    r.reply_index = reply;
    r.seen_time   = seen;
    r.term_now    = term;
    return r;
  endfunction

  // Applies one request to the follower model and returns the result it must give.
  function automatic out_t ack_predict(input in_t rq);
    out_t        r;
    logic [31:0] slot;
    bit          hit;
    r = '0;
    if (!rq.header_ok || rq.dest_port != port_q || rq.avail_len < MIN_PAYLOAD) begin
      r.outcome = OUT_NOT_OURS;
    end else if (rq.msg_type != APPEND_TYPE) begin
      r.outcome = OUT_OTHER;
    end else if (leader_q != '0 && leader_q != rq.src_addr) begin
      r.outcome = OUT_WRONG_LDR;
    end else begin
      if (leader_q == '0) leader_q = rq.src_addr;
      if ({1'b0, MIN_PAYLOAD} + {1'b0, rq.entry_len} > {1'b0, rq.avail_len}) begin
        r.outcome = OUT_TRUNC;
      end else if (rq.msg_term < cur_term) begin
        r.outcome = OUT_STALE;
      end else begin
        if (rq.msg_term > cur_term) cur_term = rq.msg_term;
        slot = rq.prior_index % RING_SLOTS;
        if (rq.prior_index == '0 && rq.prior_term == '0) begin
          hit = 1'b1;
        end else if (rq.prior_index > log_last_idx) begin
          hit = 1'b0;
        end else if (rq.prior_index == log_last_idx) begin
          hit = (rq.prior_term == log_last_term);
        end else begin
          hit = (tag_mem[slot] == rq.prior_index) && (term_mem[slot] == rq.prior_term);
        end
        if (!hit) begin
          r.outcome = OUT_MISMATCH;
        end else begin
          seen_q = rq.now_time;
          if (rq.entry_index == '0 && rq.entry_len == '0) begin
            r.outcome = OUT_HEARTBEAT;
            r.verdict = 1'b1;
          end else if (rq.entry_index == log_last_idx + 32'd1 && rq.entry_len != '0) begin
            slot = rq.entry_index % RING_SLOTS;
            tag_mem[slot]  = rq.entry_index;
            term_mem[slot] = rq.msg_term;
            log_last_idx   = rq.entry_index;
            log_last_term  = rq.msg_term;
            r.outcome        = OUT_APPENDED;
            r.verdict        = 1'b1;
            r.appended       = 1'b1;
            r.ev_term        = rq.msg_term;
            r.ev_prior_index = rq.prior_index;
            r.ev_prior_term  = rq.prior_term;
            r.ev_len         = rq.entry_len;
            r.ev_node        = rq.sender_node;
            r.ev_time        = rq.now_time;
          end else if (rq.entry_index <= log_last_idx) begin
            r.outcome = OUT_DUPLICATE;
            r.verdict = 1'b1;
          end else begin
            r.outcome = OUT_GAP;
          end
          if (r.verdict) r.reply_index = (rq.entry_index == '0) ? log_last_idx : rq.entry_index;
        end
      end
    end
    r.seen_time = seen_q;
    r.term_now  = cur_term;
    return r;
  endfunction

  // Builds a request of the given kind (0..99) around the model's current log.
  function automatic in_t next_request(input int unsigned kind);
    in_t         r;
    logic [31:0] pi;
    logic [31:0] pt;
    int unsigned back;
    int unsigned room;
    int unsigned sub;
    clock_ns = clock_ns + 64'($urandom_range(1, 100000));
    r.header_ok   = 1'b1;
    r.dest_port   = port_q;
    r.src_addr    = leader_q;
    r.msg_type    = APPEND_TYPE;
    r.msg_term    = cur_term;
    if ($urandom_range(0, 11) == 0 && cur_term < 32'hFFF0_0000) begin
      r.msg_term = cur_term + 32'($urandom_range(1, 5000));
    end
    r.sender_node = 16'($urandom);
    r.now_time    = ($urandom_range(0, 31) == 0) ? {$urandom, $urandom} : clock_ns;
    r.entry_len   = 16'($urandom_range(1, 1400));
    if ($urandom_range(0, 9) == 0) r.entry_len = 16'($urandom_range(1, 65500));
    room = 65535 - 35 - int'(r.entry_len);
    r.avail_len = 16'(35 + int'(r.entry_len) + $urandom_range(0, (room < 200) ? room : 200));
    r.entry_index = log_last_idx + 32'd1;

    // A prior entry that matches: mostly recent, sometimes deep in the ring.
    back = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, RING_SLOTS - 1);
    if (back > log_last_idx) back = log_last_idx;
    pi = log_last_idx - back;
    if (pi == '0) pt = '0;
    else if (back == 0) pt = log_last_term;
    else pt = term_mem[pi % RING_SLOTS];
    r.prior_index = pi;
    r.prior_term  = pt;
    sub = $urandom_range(0, 2);

    if (kind < 35) begin
      r.prior_index = log_last_idx;
      r.prior_term  = log_last_term;
    end else if (kind < 45) begin
      r.entry_index = '0;
      r.entry_len   = '0;
    end else if (kind < 55) begin
      r.entry_index = $urandom_range(0, log_last_idx);
    end else if (kind < 60) begin
      if (sub == 0) r.entry_len = '0;
      else r.entry_index = log_last_idx + 32'd2 + 32'($urandom_range(0, 1000));
    end else if (kind < 70) begin
      if (sub == 0) begin
        r.prior_index = log_last_idx + 32'd1 + 32'($urandom_range(0, 100000));
      end else if (sub == 1 || log_last_idx <= 32'(RING_SLOTS)) begin
        r.prior_term = pt ^ (32'd1 << $urandom_range(0, 31));
      end else begin
        // An entry that has since been overwritten by a newer index in its slot.
        r.prior_index = $urandom_range(1, log_last_idx - 32'(RING_SLOTS));
        r.prior_term  = term_mem[r.prior_index % RING_SLOTS];
      end
    end else if (kind < 75) begin
      if (cur_term != '0) r.msg_term = $urandom_range(0, cur_term - 32'd1);
    end else if (kind < 80) begin
      r.avail_len = 16'($urandom_range(35, 65535));
      r.entry_len = 16'($urandom_range(int'(r.avail_len) - 34, 65535));
    end else if (kind < 85) begin
      r.src_addr = leader_q ^ ($urandom | 32'd1);
    end else if (kind < 90) begin
      r.msg_type = 8'($urandom);
      if (r.msg_type == APPEND_TYPE) r.msg_type = r.msg_type ^ 8'h01;
    end else if (kind < 95) begin
      if (sub == 0) r.header_ok = 1'b0;
      else if (sub == 1) r.dest_port = port_q ^ (16'($urandom) | 16'd1);
      else r.avail_len = 16'($urandom_range(0, 34));
    end else begin
      r = mk(1'($urandom), 16'($urandom), $urandom, 16'($urandom), 8'($urandom), $urandom,
             $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), {$urandom, $urandom});
      if ($urandom_range(0, 1) != 0) begin
        r.header_ok = 1'b1;
        r.dest_port = port_q;
        r.src_addr  = leader_q;
        r.msg_type  = APPEND_TYPE;
        if (r.avail_len < MIN_PAYLOAD) r.avail_len = MIN_PAYLOAD;
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit allow);
    gap_count++;
    if (gap_count % 64 == 0) bursty = ($urandom_range(0, 2) != 0);
    if (!allow || !bursty || $urandom_range(0, 7) != 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  // Holds one request beat until it is taken, then records its expected result.
  task automatic send_req(input in_t rq, input bit typed, input out_t typed_ack,
                          input int unsigned gap);
    out_t ack;
    start  <= 1'b1;
    item_i <= rq;
    do @(posedge clk_i); while (busy !== 1'b0);
    ack = ack_predict(rq);
    acks_due.push_back(typed ? typed_ack : ack);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (acks_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_port(input logic [15:0] p);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    port_q = p;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (acks_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual outcome %0d",
                 $time, res_o.outcome);
        fails++;
      end else begin
        want = acks_due.pop_front();
        cmp_field("verdict", 64'(want.verdict), 64'(res_o.verdict));
        cmp_field("outcome", 64'(want.outcome), 64'(res_o.outcome));
        cmp_field("reply_index", 64'(want.reply_index), 64'(res_o.reply_index));
        cmp_field("appended", 64'(want.appended), 64'(res_o.appended));
        cmp_field("ev_term", 64'(want.ev_term), 64'(res_o.ev_term));
        cmp_field("ev_prior_index", 64'(want.ev_prior_index), 64'(res_o.ev_prior_index));
        cmp_field("ev_prior_term", 64'(want.ev_prior_term), 64'(res_o.ev_prior_term));
        cmp_field("ev_len", 64'(want.ev_len), 64'(res_o.ev_len));
        cmp_field("ev_node", 64'(want.ev_node), 64'(res_o.ev_node));
        cmp_field("ev_time", want.ev_time, res_o.ev_time);
        cmp_field("seen_time", want.seen_time, res_o.seen_time);
        cmp_field("term_now", 64'(want.term_now), 64'(res_o.term_now));
      end
    end
  end

  initial begin : stimulus
    port_q        = DEFAULT_PORT;
    cur_term      = '0;
    log_last_idx  = '0;
    log_last_term = '0;
    leader_q      = '0;
    seen_q        = '0;
    foreach (tag_mem[i]) begin
      tag_mem[i]  = '0;
      term_mem[i] = '0;
    end

    // Gate checks, leader latch and stale term, all from the reset state.
    dir_rows.push_back('{mk(1'b0, 16'd9000, LEADER_A, 16'd100, APPEND_TYPE, 32'd1, 32'd1,
                            32'd0, 32'd0, 16'd1, 16'd1, 64'd50),
                         1'b1, brief(1'b0, OUT_NOT_OURS, 32'd0, 64'd0, 32'd0)});
    dir_rows.push_back('{mk(1'b1, 16'd9001, LEADER_A, 16'd100, APPEND_TYPE, 32'd1, 32'd1,
                            32'd0, 32'd0, 16'd1, 16'd1, 64'd50),
                         1'b1, brief(1'b0, OUT_NOT_OURS, 32'd0, 64'd0, 32'd0)});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd34, APPEND_TYPE, 32'd1, 32'd0,
                            32'd0, 32'd0, 16'd1, 16'd0, 64'd50),
                         1'b1, brief(1'b0, OUT_NOT_OURS, 32'd0, 64'd0, 32'd0)});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd100, 8'h21, 32'd1, 32'd1,
                            32'd0, 32'd0, 16'd1, 16'd1, 64'd50),
                         1'b1, brief(1'b0, OUT_OTHER, 32'd0, 64'd0, 32'd0)});
    // A zero source leaves the leader unlearned; the next source is latched.
    dir_rows.push_back('{mk(1'b1, 16'd9000, 32'd0, 16'd35, APPEND_TYPE, 32'd3, 32'd0,
                            32'd0, 32'd0, 16'd1, 16'd1, 64'd60),
                         1'b1, brief(1'b0, OUT_TRUNC, 32'd0, 64'd0, 32'd0)});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd35, APPEND_TYPE, 32'd3, 32'd0,
                            32'd0, 32'd0, 16'd1, 16'd1, 64'd60),
                         1'b1, brief(1'b0, OUT_TRUNC, 32'd0, 64'd0, 32'd0)});
    dir_rows.push_back('{mk(1'b1, 16'd9000, OTHER_SRC, 16'd100, APPEND_TYPE, 32'd3, 32'd0,
                            32'd0, 32'd0, 16'd1, 16'd0, 64'd70),
                         1'b1, brief(1'b0, OUT_WRONG_LDR, 32'd0, 64'd0, 32'd0)});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd35, APPEND_TYPE, 32'd5, 32'd0,
                            32'd0, 32'd0, 16'd2, 16'd0, 64'd1000),
                         1'b1, brief(1'b1, OUT_HEARTBEAT, 32'd0, 64'd1000, 32'd5)});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd35, APPEND_TYPE, 32'd4, 32'd0,
                            32'd0, 32'd0, 16'd2, 16'd0, 64'd1100),
                         1'b1, brief(1'b0, OUT_STALE, 32'd0, 64'd1000, 32'd5)});
    // Build a short log, then probe it.
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd135, APPEND_TYPE, 32'd5, 32'd1,
                            32'd0, 32'd0, 16'd7, 16'd100, 64'd2000), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd36, APPEND_TYPE, 32'd5, 32'd2,
                            32'd1, 32'd5, 16'd7, 16'd1, 64'd2100), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd6, 32'd3,
                            32'd2, 32'd5, 16'd8, 16'd20, 64'd2200), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd6, 32'd1,
                            32'd0, 32'd0, 16'd8, 16'd10, 64'd2300), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd6, 32'd2,
                            32'd1, 32'd5, 16'd8, 16'd10, 64'd2400), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd6, 32'd9,
                            32'd3, 32'd6, 16'd8, 16'd10, 64'd2500), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd6, 32'd4,
                            32'd3, 32'd5, 16'd8, 16'd10, 64'd2600), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd6, 32'd4,
                            32'd4, 32'd6, 16'd8, 16'd10, 64'd2700), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd6, 32'd4,
                            32'd2, 32'd6, 16'd8, 16'd10, 64'd2800), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd6, 32'd4,
                            32'd0, 32'd1, 16'd8, 16'd10, 64'd2900), 1'b0, '0});
    // The raised term sticks although the prior check then fails.
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd60, APPEND_TYPE, 32'd9, 32'd4,
                            32'd2, 32'd7, 16'd8, 16'd10, 64'd3000), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd40, APPEND_TYPE, 32'd9, 32'd0,
                            32'd0, 32'd0, 16'd8, 16'd5, 64'd3100), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd40, APPEND_TYPE, 32'd9, 32'd4,
                            32'd3, 32'd6, 16'd8, 16'd0, 64'd3200), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'hFFFF, APPEND_TYPE, 32'd9, 32'd4,
                            32'd3, 32'd6, 16'hFFFF, 16'd65500, TIME_MAX), 1'b0, '0});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'hFFFF, APPEND_TYPE, 32'd9, 32'd5,
                            32'd4, 32'd9, 16'hFFFF, 16'hFFFF, 64'd3300),
                         1'b1, brief(1'b0, OUT_TRUNC, 32'd0, TIME_MAX, 32'd9)});
    dir_rows.push_back('{mk(1'b1, 16'd9000, LEADER_A, 16'd36, APPEND_TYPE, 32'd9, 32'hFFFF_FFFF,
                            32'd0, 32'd0, 16'd9, 16'd1, 64'd3400), 1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The ring is cleared after reset; busy stays high until that is done.
    do @(posedge clk_i); while (busy !== 1'b0);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want, pick_gap(1'b1));
    end

    // Grow the log to a few hundred entries so that deep ring slots get probed.
    set_port(16'hFFFF);
    while (log_last_idx < 32'(FILL_TO)) begin
      send_req(next_request(0), 1'b0, '0, pick_gap(1'b1));
    end

    set_port(16'h0000);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) set_port(16'($urandom));
      else if ($urandom_range(0, 99) == 0) drain();
      send_req(next_request($urandom_range(0, 99)), 1'b0, '0, pick_gap(n < RAND_ITEMS - 300));
    end

    drain();
    if (fails == 0) begin
      $display("consensus_append_fast_ack regression: pass");
    end else begin
      $display("consensus_append_fast_ack regression: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/cafa_pkg.sv
sv/cafa_ram.sv
sv/cafa_decide.sv
sv/consensus_append_fast_ack.sv
sv/cafa_checker.sv
dv/consensus_append_fast_ack_tb.sv
